FILE: hw/rtl/fpalu_pkg.sv
// Shared opcodes and pipeline payload types for the Q24.8 fixed-point ALU.
package fpalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_INC  = 4'd4,
    OP_DEC  = 4'd5,
    OP_MIN  = 4'd6,
    OP_MAX  = 4'd7,
    OP_I2F  = 4'd8,
    OP_F2I  = 4'd9
  } op_e;

  localparam int unsigned DataW = 32;

  // Side information that rides beside the divider.
  typedef struct packed {
    logic             use_div;
    logic             div_zero;
    logic [DataW-1:0] value;
    logic             lt;
    logic             eq;
  } side_t;

endpackage

FILE: hw/rtl/fpalu_div.sv
// Pipelined signed divider: one quotient bit per stage, stalls with the pipe.
module fpalu_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  input  fpalu_pkg::side_t       side_i,
  output logic                   valid_o,
  output logic [NumW-1:0]        quot_o,
  output fpalu_pkg::side_t       side_o
);

  localparam int unsigned Stages = NumW;

  logic                 vld_q  [Stages+1];
  logic [NumW-1:0]      quo_q  [Stages+1];
  logic [DenW:0]        rem_q  [Stages+1];
  logic [DenW-1:0]      den_q  [Stages+1];
  logic                 neg_q  [Stages+1];
  fpalu_pkg::side_t     side_q [Stages+1];

  logic [NumW-1:0] num_mag;
  logic [DenW-1:0] den_mag;

  assign num_mag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign den_mag = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);

  // Stage 0 registers magnitudes and the result sign.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q[0]  <= num_mag;
      rem_q[0]  <= '0;
      den_q[0]  <= den_mag;
      neg_q[0]  <= num_i[NumW-1] ^ den_i[DenW-1];
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [DenW:0]   shifted;
    logic [DenW+1:0] diff;
    always_comb begin
      shifted = {rem_q[s][DenW-1:0], quo_q[s][NumW-1]};
      diff    = {1'b0, shifted} - {2'b00, den_q[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!diff[DenW+1]) begin
          rem_q[s+1] <= diff[DenW:0];
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= shifted;
          quo_q[s+1] <= {quo_q[s][NumW-2:0], 1'b0};
        end
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign quot_o  = neg_q[Stages] ? NumW'(-quo_q[Stages]) : quo_q[Stages];
  assign side_o  = side_q[Stages];

endmodule

FILE: hw/rtl/fixed_point_q24_8_alu_top.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
//
// One item in, one result out. The input channel (valid_i/ready_o) takes an
// opcode and two raw 32-bit operands; the output channel (valid_o/ready_i)
// delivers result_value_o with the compare flags and the divide-by-zero flag.
//
// Throughput: one beat per cycle for every opcode unless the pipe stalls.
// All opcodes pass through the same stages, so results leave in order: the
// input register, the divider's entry register for magnitudes and sign,
// FRACTION_BITS+33 stages of a restoring divider that retires one
// quotient bit per stage (the multiplier and simple ops ride along beside
// it), then the output register: FRACTION_BITS + 36 register stages (44 at
// the default).
//
// The whole pipe advances only when the output register is empty or being
// taken, so a stalled receiver freezes every stage and nothing is lost or
// repeated; ready_o follows the same condition.
//
// Reset clears all valid bits; payload registers are not reset.
module fixed_point_q24_8_alu_top #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [3:0]          opcode_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [31:0]  result_value_o,
  output logic                a_less_than_b_o,
  output logic                a_equals_b_o,
  output logic                divide_by_zero_o
);

  localparam int unsigned DataW = fpalu_pkg::DataW;
  localparam int unsigned NumW  = DataW + FRACTION_BITS + 1;

  logic en;
  logic out_vld_q;
  assign en      = !out_vld_q || ready_i;
  assign ready_o = en;

  // Input stage: register the beat; the multiply runs here.
  logic                    s1_vld_q;
  logic [3:0]              op_q;
  logic signed [DataW-1:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= opcode_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
    end
  end

  logic signed [2*DataW-1:0] prod;
  logic signed [2*DataW-1:0] prod_sh;
  logic                      lt, eq;
  logic [DataW-1:0]          simple_d;
  fpalu_pkg::side_t          side_d;
  logic signed [NumW-1:0]    num;

  assign prod    = a_q * b_q;
  assign prod_sh = prod >>> FRACTION_BITS;
  assign lt      = a_q < b_q;
  assign eq      = a_q == b_q;
  assign num     = NumW'(a_q) <<< FRACTION_BITS;

  always_comb begin
    case (op_q)
      fpalu_pkg::OP_ADD: simple_d = a_q + b_q;
      fpalu_pkg::OP_SUB: simple_d = a_q - b_q;
      fpalu_pkg::OP_MUL: simple_d = prod_sh[DataW-1:0];
      fpalu_pkg::OP_INC: simple_d = a_q + DataW'(1);
      fpalu_pkg::OP_DEC: simple_d = a_q - DataW'(1);
      fpalu_pkg::OP_MIN: simple_d = lt ? a_q : b_q;
      fpalu_pkg::OP_MAX: simple_d = (!lt && !eq) ? a_q : b_q;
      fpalu_pkg::OP_I2F: simple_d = a_q << FRACTION_BITS;
      fpalu_pkg::OP_F2I: simple_d = a_q >>> FRACTION_BITS;
      default:           simple_d = '0;
    endcase
    side_d.use_div  = (op_q == fpalu_pkg::OP_DIV);
    side_d.div_zero = (op_q == fpalu_pkg::OP_DIV) && (b_q == '0);
    side_d.value    = simple_d;
    side_d.lt       = lt;
    side_d.eq       = eq;
  end

  logic             dv_vld;
  logic [NumW-1:0]  quot;
  fpalu_pkg::side_t side_o_w;

  fpalu_div #(
    .NumW(NumW),
    .DenW(DataW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_vld_q),
    .num_i   (num),
    .den_i   (b_q),
    .side_i  (side_d),
    .valid_o (dv_vld),
    .quot_o  (quot),
    .side_o  (side_o_w)
  );

  // Output register: select divider or side result (zero on divide by zero), hold while stalled.
  logic [DataW-1:0] res_q;
  logic             lt_q, eq_q, dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_o_w.div_zero) begin
        res_q <= '0;
      end else if (side_o_w.use_div) begin
        res_q <= quot[DataW-1:0];
      end else begin
        res_q <= side_o_w.value;
      end
      lt_q <= side_o_w.lt;
      eq_q <= side_o_w.eq;
      dz_q <= side_o_w.div_zero;
    end
  end

  assign valid_o          = out_vld_q;
  assign result_value_o   = res_q;
  assign a_less_than_b_o  = lt_q;
  assign a_equals_b_o     = eq_q;
  assign divide_by_zero_o = dz_q;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU pipeline.
`timescale 1ns / 100ps

module tb;

  localparam int FracBits  = 8;
  localparam int NumRandom = 1530;
  localparam int MaxCycles = 400000;
  localparam int Latency   = FracBits + 36;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic               lt;
    logic               eq;
    logic               dz;
  } alu_rsp_t;

  logic               clk_i, rst_ni;
  logic               valid_i, ready_o, valid_o, ready_i;
  logic [3:0]         opcode_i;
  logic signed [31:0] operand_a_i, operand_b_i;
  logic signed [31:0] result_value_o;
  logic               a_less_than_b_o, a_equals_b_o, divide_by_zero_o;

  alu_req_t pending_q[$];
  alu_rsp_t expected_q[$];
  int       errors;
  int       cycles;
  int       results_seen;
  bit       quiet_phase;
  bit       in_fire;
  int       hold_off;

  fixed_point_q24_8_alu_top #(.FRACTION_BITS(FracBits)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic alu_rsp_t predict_alu(alu_req_t r);
    alu_rsp_t         p;
    logic signed [63:0] wide;
    logic signed [63:0] dividend;
    p.lt    = r.a < r.b;
    p.eq    = r.a == r.b;
    p.dz    = 1'b0;
    p.value = '0;
    case (r.op)
      fpalu_pkg::OP_ADD: p.value = r.a + r.b;
      fpalu_pkg::OP_SUB: p.value = r.a - r.b;
      fpalu_pkg::OP_MUL: begin
        wide    = 64'(r.a) * 64'(r.b);
        p.value = 32'(wide >>> FracBits);
      end
      fpalu_pkg::OP_DIV: begin
        if (r.b == 0) begin
          p.dz = 1'b1;
        end else begin
          dividend = 64'(r.a) <<< FracBits;
          wide     = dividend / 64'(r.b);
          p.value  = wide[31:0];
        end
      end
      fpalu_pkg::OP_INC: p.value = r.a + 32'sd1;
      fpalu_pkg::OP_DEC: p.value = r.a - 32'sd1;
      fpalu_pkg::OP_MIN: p.value = (r.a < r.b) ? r.a : r.b;
      fpalu_pkg::OP_MAX: p.value = (r.a > r.b) ? r.a : r.b;
      fpalu_pkg::OP_I2F: p.value = r.a <<< FracBits;
      fpalu_pkg::OP_F2I: p.value = r.a >>> FracBits;
      default: p.value = '0;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0d] mismatch on %s: got %h, want %h", cycles, what, got, want);
    errors++;
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 1024)) - 512;
      4: return 32'(($urandom_range(0, 1) ? 1 : -1)) * 256;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
    alu_req_t r;
    r.op = op; r.a = a; r.b = b;
    pending_q.push_back(r);
  endtask

  // Driver: present beats at the falling edge, idle in bursts.
  int send_gap;
  initial begin
    valid_i = 0; opcode_i = '0; operand_a_i = '0; operand_b_i = '0; send_gap = 0;
  end
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || in_fire) begin
        if (send_gap > 0) begin
          send_gap--;
          valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          opcode_i    <= pending_q[0].op;
          operand_a_i <= pending_q[0].a;
          operand_b_i <= pending_q[0].b;
          valid_i     <= 1'b1;
          pending_q.pop_front();
          if (!quiet_phase && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Accepted input beats feed the predictor.
  alu_req_t accepted;
  initial in_fire = 1'b0;
  always @(posedge clk_i) begin
    in_fire = rst_ni && valid_i && ready_o;
    if (in_fire) begin
      accepted.op = opcode_i; accepted.a = operand_a_i; accepted.b = operand_b_i;
      expected_q.push_back(predict_alu(accepted));
    end
  end

  // Receiver ready: random bursts, plus one long hold-off.
  int recv_gap;
  initial begin
    ready_i = 0; recv_gap = 0; hold_off = 0;
  end
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      ready_i <= 1'b0;
    end else begin
      ready_i <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 9);
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  alu_rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("[%0d] result beat with nothing expected", cycles);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (result_value_o !== want.value)
          report_mismatch("result_value", result_value_o, want.value);
        if (a_less_than_b_o !== want.lt)
          report_mismatch("a_less_than_b", a_less_than_b_o, want.lt);
        if (a_equals_b_o !== want.eq)
          report_mismatch("a_equals_b", a_equals_b_o, want.eq);
        if (divide_by_zero_o !== want.dz)
          report_mismatch("divide_by_zero", divide_by_zero_o, want.dz);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [3:0] op;
    errors = 0; cycles = 0; results_seen = 0; quiet_phase = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: every opcode at the corners, ties, divide by zero, unused codes.
    for (int o = 0; o <= 9; o++) push_item(4'(o), 32'sh7fffffff, 32'sh80000000);
    push_item(fpalu_pkg::OP_DIV, 32'sd1000, 0);
    push_item(fpalu_pkg::OP_DIV, 32'sh80000000, -32'sd1);
    push_item(fpalu_pkg::OP_DIV, -32'sd768, 32'sd512);
    push_item(fpalu_pkg::OP_MUL, 32'sh80000000, 32'sh80000000);
    push_item(fpalu_pkg::OP_MUL, -32'sd1, 32'sd1);
    push_item(fpalu_pkg::OP_MIN, 32'sd5, 32'sd5);
    push_item(fpalu_pkg::OP_MAX, -32'sd7, -32'sd7);
    push_item(fpalu_pkg::OP_INC, 32'sh7fffffff, 0);
    push_item(fpalu_pkg::OP_DEC, 32'sh80000000, 0);
    push_item(fpalu_pkg::OP_F2I, -32'sd1, 0);
    push_item(fpalu_pkg::OP_I2F, 32'shffffffff, 0);
    push_item(4'd10, 32'sd3, 32'sd4);
    push_item(4'd15, -32'sd1, -32'sd1);

    // Stall the receiver long enough for the pipe to fill and backpressure.
    wait (pending_q.size() == 0);
    hold_off = 150;
    for (int i = 0; i < 200; i++) push_item(4'($urandom_range(0, 9)), pick_operand(), pick_operand());

    for (int i = 0; i < NumRandom - 200; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      if (i == NumRandom - 300) begin
        wait (pending_q.size() < 4);
        quiet_phase = 1;
      end
      if (op == fpalu_pkg::OP_DIV && $urandom_range(0, 15) == 0) push_item(op, pick_operand(), 0);
      else push_item(op, pick_operand(), pick_operand());
    end

    wait (pending_q.size() == 0 && !valid_i);
    @(posedge clk_i);
    wait (expected_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);

    $display("covered all ten opcodes plus unused codes, corner operands, divide by zero,");
    $display("%0d result beats checked with random stalls and one long output hold-off",
             results_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
